// File: rtl/xfd_pkg.sv
// Package for the x86-64 instruction field decoder.
// Holds the result word type, status codes and opcode/ModRM decode functions.
// No dependencies.
`default_nettype none

package xfd_pkg;

    localparam int MAX_LENGTH_DEF = 15;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
    localparam logic [1:0] STATUS_LIMIT   = 2'd2;

    localparam logic [2:0] SIZE_0  = 3'd0;
    localparam logic [2:0] SIZE_8  = 3'd1;
    localparam logic [2:0] SIZE_32 = 3'd4;

    localparam logic [1:0] MOD_MEM    = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_RIP     = 3'd5;
    localparam logic [2:0] BASE_NONE  = 3'd5;
    localparam logic [3:0] REX_HI     = 4'h4;

    typedef struct packed {
        logic       known;
        logic       modrm;
        logic [2:0] imm_size;
    } op_info_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  length;
        logic [7:0]  opcode;
        logic [3:0]  prefix_count;
        logic        rex_present;
        logic [3:0]  rex_wrxb;
        logic        has_modrm;
        logic [7:0]  modrm;
        logic        has_sib;
        logic [7:0]  sib;
        logic [31:0] displacement;
        logic [31:0] immediate;
    } rec_t;

    function automatic op_info_t op_info(input logic [7:0] op);
        op_info_t info;
        info = '0;
        case (op) inside
            8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h09, 8'h0A, 8'h0B,
            8'h2B, 8'h32, 8'h33, 8'h38, 8'h39, 8'h3B, 8'h84, 8'h85,
            [8'h88:8'h8B], 8'h8D:
                info = '{known: 1'b1, modrm: 1'b1, imm_size: SIZE_0};
            8'h6B, 8'h83, 8'hC1:
                info = '{known: 1'b1, modrm: 1'b1, imm_size: SIZE_8};
            8'h81, 8'hC7:
                info = '{known: 1'b1, modrm: 1'b1, imm_size: SIZE_32};
            8'h04, 8'h0C, 8'h73, 8'h74, 8'h75:
                info = '{known: 1'b1, modrm: 1'b0, imm_size: SIZE_8};
            8'h05, 8'h0D, 8'h3D, 8'hB8, 8'hB9, 8'hC2, 8'hE8, 8'hE9:
                info = '{known: 1'b1, modrm: 1'b0, imm_size: SIZE_32};
            8'h53, 8'h55, 8'h56, 8'h57, 8'h5D, 8'h5E, 8'hC3:
                info = '{known: 1'b1, modrm: 1'b0, imm_size: SIZE_0};
            default:
                info = '0;
        endcase
        return info;
    endfunction

    function automatic logic is_legacy(input logic [7:0] b);
        return b inside {8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h26,
                         8'h64, 8'h65, 8'h3E, 8'h66, 8'h67};
    endfunction

    function automatic logic sib_follows(input logic [7:0] m);
        return (m[7:6] != MOD_REG) && (m[2:0] == RM_SIB);
    endfunction

    function automatic logic [2:0] disp_size(input logic [7:0] m, input logic [7:0] s);
        logic [2:0] n;
        n = SIZE_0;
        case (m[7:6])
            MOD_DISP8:  n = SIZE_8;
            MOD_DISP32: n = SIZE_32;
            MOD_MEM:
            begin
                if (m[2:0] == RM_RIP)
                    n = SIZE_32;
                else if (m[2:0] == RM_SIB && s[2:0] == BASE_NONE)
                    n = SIZE_32;
            end
            default:    n = SIZE_0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/xfd_parse.sv
// Parse state and one-byte step logic of the instruction field decoder.
// Depends on xfd_pkg for decode functions, status codes and rec_t.
`default_nettype none

module xfd_parse #(
    parameter int MAX_LENGTH = xfd_pkg::MAX_LENGTH_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               step_en,
    input  wire  [7:0]        code_byte,
    output logic              emit,
    output xfd_pkg::rec_t     rec
);

    localparam logic [3:0] MAX_LEN = 4'(MAX_LENGTH);

    localparam logic [2:0] PH_PREFIX = 3'd0;
    localparam logic [2:0] PH_OPCODE = 3'd1;
    localparam logic [2:0] PH_MODRM  = 3'd2;
    localparam logic [2:0] PH_SIB    = 3'd3;
    localparam logic [2:0] PH_DISP   = 3'd4;
    localparam logic [2:0] PH_IMM    = 3'd5;

    logic [2:0]  phase_reg,        phase_next;
    logic [3:0]  byte_count_reg,   byte_count_next;
    logic [3:0]  prefix_total_reg, prefix_total_next;
    logic [4:0]  rex_reg,          rex_next;
    logic [7:0]  opcode_reg,       opcode_next;
    logic [7:0]  modrm_reg,        modrm_next;
    logic [7:0]  sib_reg,          sib_next;
    logic [31:0] disp_reg,         disp_next;
    logic [31:0] imm_reg,          imm_next;
    logic [2:0]  bytes_left_reg,   bytes_left_next;

    logic [3:0]  count;
    logic        done;
    logic        full;
    logic        addr_done;
    logic        imm_start;
    logic        hm;
    logic        hs;
    logic [1:0]  st;
    logic [1:0]  idx;
    logic [2:0]  dsz;
    logic [2:0]  isz;
    xfd_pkg::op_info_t info;

    always_comb
    begin
        count             = byte_count_reg + 4'd1;
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        prefix_total_next = prefix_total_reg;
        rex_next          = rex_reg;
        opcode_next       = opcode_reg;
        modrm_next        = modrm_reg;
        sib_next          = sib_reg;
        disp_next         = disp_reg;
        imm_next          = imm_reg;
        bytes_left_next   = bytes_left_reg;
        done              = 1'b0;
        full              = 1'b0;
        emit              = 1'b0;
        addr_done         = 1'b0;
        imm_start         = 1'b0;
        st                = xfd_pkg::STATUS_OK;
        idx               = 2'd0;
        dsz               = xfd_pkg::SIZE_0;
        isz               = xfd_pkg::SIZE_0;
        info              = xfd_pkg::op_info(code_byte);

        if (phase_reg == PH_PREFIX &&
            (xfd_pkg::is_legacy(code_byte) || code_byte[7:4] == xfd_pkg::REX_HI))
        begin
            if (count >= MAX_LEN)
            begin
                emit = 1'b1;
                st   = xfd_pkg::STATUS_LIMIT;
            end
            else
            begin
                if (xfd_pkg::is_legacy(code_byte))
                    prefix_total_next = prefix_total_reg + 4'd1;
                else
                begin
                    rex_next   = {1'b1, code_byte[3:0]};
                    phase_next = PH_OPCODE;
                end
                byte_count_next = count;
            end
        end
        else
        begin
            case (phase_reg)
                PH_MODRM:
                begin
                    modrm_next = code_byte;
                    if (xfd_pkg::sib_follows(code_byte))
                        phase_next = PH_SIB;
                    else
                        addr_done = 1'b1;
                end
                PH_SIB:
                begin
                    sib_next  = code_byte;
                    addr_done = 1'b1;
                end
                PH_DISP:
                begin
                    dsz = xfd_pkg::disp_size(modrm_reg, sib_reg);
                    idx = 2'(dsz - bytes_left_reg);
                    disp_next[{idx, 3'b000} +: 8] = disp_reg[{idx, 3'b000} +: 8] | code_byte;
                    bytes_left_next = bytes_left_reg - 3'd1;
                    if (bytes_left_next == 3'd0 || idx == 2'd3)
                    begin
                        if (dsz == xfd_pkg::SIZE_8 && disp_next[7])
                            disp_next[31:8] = '1;
                        imm_start = 1'b1;
                    end
                end
                PH_IMM:
                begin
                    isz = xfd_pkg::op_info(opcode_reg).imm_size;
                    idx = 2'(isz - bytes_left_reg);
                    imm_next[{idx, 3'b000} +: 8] = imm_reg[{idx, 3'b000} +: 8] | code_byte;
                    bytes_left_next = bytes_left_reg - 3'd1;
                    if (bytes_left_next == 3'd0 || idx == 2'd3)
                        done = 1'b1;
                end
                default:
                begin
                    opcode_next = code_byte;
                    if (!info.known)
                    begin
                        emit = 1'b1;
                        st   = xfd_pkg::STATUS_UNKNOWN;
                    end
                    else if (info.modrm)
                        phase_next = PH_MODRM;
                    else
                        imm_start = 1'b1;
                end
            endcase

            if (addr_done)
            begin
                dsz = xfd_pkg::disp_size(modrm_next, sib_next);
                if (dsz == xfd_pkg::SIZE_0)
                    imm_start = 1'b1;
                else
                begin
                    phase_next      = PH_DISP;
                    bytes_left_next = dsz;
                end
            end

            if (imm_start)
            begin
                isz = xfd_pkg::op_info(opcode_next).imm_size;
                if (isz == xfd_pkg::SIZE_0)
                    done = 1'b1;
                else
                begin
                    phase_next      = PH_IMM;
                    bytes_left_next = isz;
                end
            end

            if (!emit)
            begin
                if (done)
                begin
                    emit = 1'b1;
                    full = 1'b1;
                    st   = xfd_pkg::STATUS_OK;
                end
                else if (count >= MAX_LEN)
                begin
                    emit = 1'b1;
                    st   = xfd_pkg::STATUS_LIMIT;
                end
                else
                    byte_count_next = count;
            end
        end

        hm = full && xfd_pkg::op_info(opcode_next).modrm;
        hs = hm && xfd_pkg::sib_follows(modrm_next);

        rec.status       = st;
        rec.length       = count;
        rec.opcode       = opcode_next;
        rec.prefix_count = prefix_total_next;
        rec.rex_present  = rex_next[4];
        rec.rex_wrxb     = rex_next[3:0];
        rec.has_modrm    = hm;
        rec.modrm        = hm ? modrm_next : 8'h00;
        rec.has_sib      = hs;
        rec.sib          = hs ? sib_next : 8'h00;
        rec.displacement = full ? disp_next : 32'h0;
        rec.immediate    = full ? imm_next : 32'h0;

        // resync after every emitted word
        if (emit)
        begin
            phase_next        = PH_PREFIX;
            byte_count_next   = 4'd0;
            prefix_total_next = 4'd0;
            rex_next          = 5'd0;
            opcode_next       = 8'h00;
            modrm_next        = 8'h00;
            sib_next          = 8'h00;
            disp_next         = 32'h0;
            imm_next          = 32'h0;
            bytes_left_next   = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PREFIX;
            byte_count_reg   <= 4'd0;
            prefix_total_reg <= 4'd0;
            rex_reg          <= 5'd0;
            opcode_reg       <= 8'h00;
            modrm_reg        <= 8'h00;
            sib_reg          <= 8'h00;
            disp_reg         <= 32'h0;
            imm_reg          <= 32'h0;
            bytes_left_reg   <= 3'd0;
        end
        else if (step_en)
        begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            prefix_total_reg <= prefix_total_next;
            rex_reg          <= rex_next;
            opcode_reg       <= opcode_next;
            modrm_reg        <= modrm_next;
            sib_reg          <= sib_next;
            disp_reg         <= disp_next;
            imm_reg          <= imm_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/x86_64_instruction_field_decoder_core.sv
// A code byte is held in the byte register, and the word it completes is then registered
// in the result register; one code byte per cycle, stalls only when the result word is held.
// The byte register and result register keep both sides decoupled.
// Reset (rst_n low, async) empties both registers and returns the parser to
// the prefix phase with all held fields cleared.
// Depends on xfd_pkg and xfd_parse.
`default_nettype none

module x86_64_instruction_field_decoder_core #(
    parameter int MAX_LENGTH = xfd_pkg::MAX_LENGTH_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                byte_valid,
    output logic               byte_ready,
    input  wire  [7:0]         code_byte,
    output logic               result_valid,
    input  wire                result_ready,
    output logic [1:0]         status,
    output logic [3:0]         length,
    output logic [7:0]         opcode,
    output logic [3:0]         prefix_count,
    output logic               rex_present,
    output logic [3:0]         rex_wrxb,
    output logic               has_modrm,
    output logic [7:0]         modrm,
    output logic               has_sib,
    output logic [7:0]         sib,
    output logic signed [31:0] displacement,
    output logic [31:0]        immediate
);

    logic          in_valid_reg;
    logic [7:0]    byte_reg;
    logic          out_valid_reg;
    xfd_pkg::rec_t rec_reg;
    xfd_pkg::rec_t rec;
    logic          emit;
    logic          out_free;
    logic          step_en;

    assign out_free   = !out_valid_reg || result_ready;
    assign step_en    = in_valid_reg && out_free;
    assign byte_ready = !in_valid_reg || out_free;

    xfd_parse #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .code_byte (byte_reg),
        .emit      (emit),
        .rec       (rec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_ready)
                in_valid_reg <= byte_valid;
            if (step_en && emit)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
            byte_reg <= code_byte;
        if (step_en && emit)
            rec_reg <= rec;
    end

    assign result_valid = out_valid_reg;
    assign status       = rec_reg.status;
    assign length       = rec_reg.length;
    assign opcode       = rec_reg.opcode;
    assign prefix_count = rec_reg.prefix_count;
    assign rex_present  = rec_reg.rex_present;
    assign rex_wrxb     = rec_reg.rex_wrxb;
    assign has_modrm    = rec_reg.has_modrm;
    assign modrm        = rec_reg.modrm;
    assign has_sib      = rec_reg.has_sib;
    assign sib          = rec_reg.sib;
    assign displacement = rec_reg.displacement;
    assign immediate    = rec_reg.immediate;

`ifndef SYNTHESIS
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == xfd_pkg::STATUS_OK || status == xfd_pkg::STATUS_UNKNOWN
                          || status == xfd_pkg::STATUS_LIMIT))
        else $error("illegal status code");

    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (length != 4'd0 && length <= 4'(MAX_LENGTH)
                          && prefix_count < length))
        else $error("length out of range");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != xfd_pkg::STATUS_OK) |->
            (!has_modrm && !has_sib && displacement == 32'sd0 && immediate == 32'd0))
        else $error("error word carries operand fields");

    a_sib_needs_modrm: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && has_sib) |->
            (has_modrm && modrm[2:0] == xfd_pkg::RM_SIB && modrm[7:6] != xfd_pkg::MOD_REG))
        else $error("SIB without matching ModRM");
`endif

endmodule

`default_nettype wire
